### rtl/core/acsa_pkg.sv
// Shared types and constants for the argmax class scatter-accumulate block.
// No dependencies; every other file in rtl/core depends on this package.
package acsa_pkg;

    typedef logic signed [15:0] q_t;

    // Column that carries the -1.0 bias
    localparam int unsigned BIAS_COLUMN = 2;

    localparam logic MODE_ELEMENT = 1'b0;
    localparam logic MODE_DRAIN   = 1'b1;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_TABLE   = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;    // clearing pass, one table word per cycle
        logic elem;      // process the accepted row element
        logic drain_rd;  // issue table read for the accepted drain
        logic drain_wr;  // present drained word, zero the entry
        logic acc_step;  // one step of the row-end accumulate
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic row_end;
        logic acc_done;
    } stat_t;

endpackage

### rtl/core/acsa_in_if.sv
// Input channel: valid/ready handshake carrying one row element or drain request.
// Depends on acsa_pkg.
interface acsa_in_if;
    logic           valid;
    logic           ready;
    logic           mode;
    acsa_pkg::q_t   value;
    logic           row_masked;

    modport source (output valid, mode, value, row_masked, input ready);
    modport sink   (input valid, mode, value, row_masked, output ready);
endinterface

### rtl/core/acsa_out_if.sv
// Output channel: valid/ready handshake carrying one result beat.
// Depends on acsa_pkg.
interface acsa_out_if;
    logic           valid;
    logic           ready;
    logic           kind;
    acsa_pkg::q_t   result_value;
    logic           last;

    modport source (output valid, kind, result_value, last, input ready);
    modport sink   (input valid, kind, result_value, last, output ready);
endinterface

### rtl/core/acsa_ctrl.sv
// Controller FSM: table clear after reset, element/drain dispatch, row-end accumulate.
// Depends on acsa_pkg for the command and status structs.
module acsa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_mode,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  acsa_pkg::stat_t stat,
    output acsa_pkg::cmd_t  cmd
);
    import acsa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ACC   = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // Output slot must be empty or emptying before a new beat is taken
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_DRAIN)
                    begin
                        cmd.drain_rd = 1'b1;
                        state_next   = S_DRAIN;
                    end
                    else
                    begin
                        cmd.elem       = 1'b1;
                        out_valid_next = 1'b1;
                        if (stat.row_end)
                        begin
                            state_next = S_ACC;
                        end
                    end
                end
            end
            S_ACC:
            begin
                cmd.acc_step = 1'b1;
                if (stat.acc_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                cmd.drain_wr   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/acsa_dp.sv
// Datapath: element remask/bias, argmax tracking, row buffer and class-sum memories,
// output payload register. Depends on acsa_pkg; driven by acsa_ctrl commands.
module acsa_dp #(
    parameter int ROW_WIDTH = 16,
    parameter int CLASSES   = 4,
    parameter int FRAC_BITS = 9
) (
    input  logic            clk,
    input  logic            rst_n,
    input  acsa_pkg::cmd_t  cmd,
    output acsa_pkg::stat_t stat,
    input  acsa_pkg::q_t    in_value,
    input  logic            in_row_masked,
    output logic            out_kind,
    output acsa_pkg::q_t    out_result_value,
    output logic            out_last
);
    import acsa_pkg::*;

    localparam int TABLE_SIZE  = CLASSES * ROW_WIDTH;
    localparam int ARG_COLUMNS = (CLASSES < ROW_WIDTH) ? CLASSES : ROW_WIDTH;
    localparam int COL_W       = $clog2(ROW_WIDTH);
    localparam int K_W         = $clog2(ROW_WIDTH + 1);
    localparam int CLS_W       = $clog2(CLASSES);
    localparam int TAB_AW      = $clog2(TABLE_SIZE);
    localparam logic [15:0] BIAS = 16'(1 << FRAC_BITS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(ROW_WIDTH - 1);
    localparam logic [TAB_AW-1:0] LAST_ADDR = TAB_AW'(TABLE_SIZE - 1);

    // Memories
    logic [15:0] row_mem [ROW_WIDTH];
    logic [15:0] sum_mem [TABLE_SIZE];
    logic [15:0] row_rd_reg;
    logic [15:0] sum_rd_reg;

    // Control-side state
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    q_t                best_reg;
    q_t                best_next;
    logic [CLS_W-1:0]  cls_reg;
    logic [CLS_W-1:0]  cls_next;
    logic [TAB_AW-1:0] drain_ptr_reg;
    logic [TAB_AW-1:0] drain_ptr_next;
    logic [TAB_AW-1:0] clr_addr_reg;
    logic [TAB_AW-1:0] clr_addr_next;
    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    k_next;
    logic              pend_reg;
    logic              pend_next;

    // Payload-only registers
    logic [COL_W-1:0]  pend_col_reg;
    logic [TAB_AW-1:0] drain_addr_reg;
    logic              out_kind_reg;
    q_t                out_value_reg;
    logic              out_last_reg;

    logic [15:0]       x;
    logic [TAB_AW-1:0] base;
    logic [TAB_AW-1:0] sum_ra;
    logic              sum_we;
    logic [TAB_AW-1:0] sum_wa;
    logic [15:0]       sum_wd;

    // Remask, then bias on the bias column
    always_comb
    begin
        x = in_row_masked ? 16'h0000 : in_value;
        if (col_reg == COL_W'(BIAS_COLUMN))
        begin
            x = x - BIAS;
        end
    end

    assign base = TAB_AW'(cls_reg * ROW_WIDTH);

    assign stat.clr_done = (clr_addr_reg == LAST_ADDR);
    assign stat.row_end  = (col_reg == LAST_COL);
    assign stat.acc_done = (k_reg == K_W'(ROW_WIDTH));

    // Argmax tracking and column counter
    always_comb
    begin
        col_next  = col_reg;
        best_next = best_reg;
        cls_next  = cls_reg;
        if (cmd.elem)
        begin
            col_next = (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
            if (col_reg == '0)
            begin
                best_next = q_t'(x);
                cls_next  = '0;
            end
            else if ((int'(col_reg) < ARG_COLUMNS) && ($signed(x) > best_reg))
            begin
                best_next = q_t'(x);
                cls_next  = CLS_W'(col_reg);
            end
        end
    end

    // Row-end accumulate sequencing: read at k, write back in the following cycle
    always_comb
    begin
        k_next    = k_reg;
        pend_next = 1'b0;
        if (cmd.acc_step)
        begin
            pend_next = !stat.acc_done;
            k_next    = stat.acc_done ? '0 : k_reg + 1'b1;
        end
    end

    assign clr_addr_next  = cmd.clr_en ? clr_addr_reg + 1'b1 : clr_addr_reg;
    assign drain_ptr_next = !cmd.drain_rd ? drain_ptr_reg
                          : (drain_ptr_reg == LAST_ADDR) ? '0 : drain_ptr_reg + 1'b1;

    // Class-sum memory port selection
    always_comb
    begin
        sum_ra = cmd.drain_rd ? drain_ptr_reg : base + TAB_AW'(k_reg[COL_W-1:0]);
        sum_we = 1'b0;
        sum_wa = base + TAB_AW'(pend_col_reg);
        sum_wd = sum_rd_reg + row_rd_reg;
        if (cmd.clr_en)
        begin
            sum_we = 1'b1;
            sum_wa = clr_addr_reg;
            sum_wd = '0;
        end
        else if (cmd.drain_wr)
        begin
            sum_we = 1'b1;
            sum_wa = drain_addr_reg;
            sum_wd = '0;
        end
        else if (pend_reg)
        begin
            sum_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wa] <= sum_wd;
        end
        sum_rd_reg <= sum_mem[sum_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.elem)
        begin
            row_mem[col_reg] <= x;
        end
        row_rd_reg <= row_mem[k_reg[COL_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        pend_col_reg <= k_reg[COL_W-1:0];
        if (cmd.drain_rd)
        begin
            drain_addr_reg <= drain_ptr_reg;
        end
        if (cmd.elem)
        begin
            out_kind_reg  <= KIND_ELEMENT;
            out_value_reg <= q_t'(x);
            out_last_reg  <= 1'b0;
        end
        else if (cmd.drain_wr)
        begin
            out_kind_reg  <= KIND_TABLE;
            out_value_reg <= q_t'(sum_rd_reg);
            out_last_reg  <= (drain_addr_reg == LAST_ADDR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            best_reg      <= '0;
            cls_reg       <= '0;
            drain_ptr_reg <= '0;
            clr_addr_reg  <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            best_reg      <= best_next;
            cls_reg       <= cls_next;
            drain_ptr_reg <= drain_ptr_next;
            clr_addr_reg  <= clr_addr_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
        end
    end

    assign out_kind         = out_kind_reg;
    assign out_result_value = out_value_reg;
    assign out_last         = out_last_reg;

endmodule

### rtl/core/argmax_class_scatter_accumulate.sv
// Row element beat: result in the cycle after accept; next beat may follow at once while the output slot is free.
// Drain beat: table word read on accept, registered into the output in the drain state, input ready low in between.
// Last column of a row: input held off in the accumulate state while the row is
// added into the class-sum memory, one word per cycle over its single write port.
// Reset: async, active low; then a clearing pass over all CLASSES*ROW_WIDTH words with
// input ready low before the first beat is taken.
module argmax_class_scatter_accumulate #(
    parameter int ROW_WIDTH = 16,
    parameter int CLASSES   = 4,
    parameter int FRAC_BITS = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    acsa_in_if.sink    din,
    acsa_out_if.source dout
);
    import acsa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    acsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_mode   (din.mode),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    acsa_dp #(
        .ROW_WIDTH (ROW_WIDTH),
        .CLASSES   (CLASSES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_value         (din.value),
        .in_row_masked    (din.row_masked),
        .out_kind         (dout.kind),
        .out_result_value (dout.result_value),
        .out_last         (dout.last)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for argmax_class_scatter_accumulate: directed and random rows plus
// table drains, predicted in-bench. Depends on acsa_pkg, acsa_in_if, acsa_out_if and the RTL.
module tb;

    import acsa_pkg::*;

    localparam int ROW_WIDTH   = 16;
    localparam int CLASSES     = 4;
    localparam int FRAC_BITS   = 9;
    localparam int TABLE_WORDS = CLASSES * ROW_WIDTH;
    localparam int ARG_COLUMNS = (CLASSES < ROW_WIDTH) ? CLASSES : ROW_WIDTH;
    localparam q_t ONE_Q       = q_t'(1 << FRAC_BITS);
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic kind;
        q_t   data;
        logic last;
    } out_beat_t;

    logic clk;
    logic rst_n;

    acsa_in_if  din ();
    acsa_out_if dout ();

    argmax_class_scatter_accumulate #(
        .ROW_WIDTH (ROW_WIDTH),
        .CLASSES   (CLASSES),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    // Predicted block state
    int unsigned col_count;
    q_t          best_val;
    int unsigned best_cls;
    q_t          row_buf [ROW_WIDTH];
    q_t          class_sums [TABLE_WORDS];
    int unsigned drain_ptr;

    out_beat_t   pending_beats [$];

    int unsigned source_gap_pct;
    int unsigned sink_hold_pct;
    int unsigned mismatches;
    int unsigned elem_beats;
    int unsigned drain_beats;
    int unsigned rows_closed;
    int unsigned table_passes;
    int unsigned stall_cycles;

    out_beat_t   rx_got;
    out_beat_t   rx_want;

    always #1 clk = ~clk;

    // One accepted input beat: update the predicted state and queue the result it causes.
    function automatic void scatter_accumulate_step(input logic mode, input q_t value,
                                                     input logic masked);
        out_beat_t   beat;
        q_t          x;
        int unsigned col;
        if (mode == MODE_DRAIN)
        begin
            beat.kind = KIND_TABLE;
            beat.data = class_sums[drain_ptr];
            beat.last = (drain_ptr == TABLE_WORDS - 1);
            class_sums[drain_ptr] = '0;
            if (beat.last)
                table_passes++;
            drain_ptr = (drain_ptr == TABLE_WORDS - 1) ? 0 : drain_ptr + 1;
            drain_beats++;
        end
        else
        begin
            col = col_count;
            x = masked ? q_t'(0) : value;
            if (col == BIAS_COLUMN)
                x = x - ONE_Q;
            row_buf[col] = x;
            if (col == 0)
            begin
                best_val = x;
                best_cls = 0;
            end
            else if (col < ARG_COLUMNS && x > best_val)
            begin
                best_val = x;
                best_cls = col;
            end
            if (col == ROW_WIDTH - 1)
            begin
                for (int k = 0; k < ROW_WIDTH; k++)
                    class_sums[best_cls * ROW_WIDTH + k] =
                        class_sums[best_cls * ROW_WIDTH + k] + row_buf[k];
                col_count = 0;
                rows_closed++;
            end
            else
            begin
                col_count = col + 1;
            end
            beat.kind = KIND_ELEMENT;
            beat.data = x;
            beat.last = 1'b0;
            elem_beats++;
        end
        pending_beats.push_back(beat);
    endfunction

    function automatic void report_mismatch(input string what, input out_beat_t want,
                                            input out_beat_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected kind=%0d value=%0d last=%0d, got kind=%0d value=%0d last=%0d",
                     what, want.kind, want.data, want.last, got.kind, got.data, got.last);
    endfunction

    function automatic q_t pick_element();
        case ($urandom_range(5))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return q_t'($urandom_range(2));
            3:       return -q_t'($urandom_range(2));
            default: return q_t'($urandom);
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic mode, input q_t value, input logic masked);
        while ($urandom_range(99) < source_gap_pct)
        begin
            din.valid <= 1'b0;
            @(posedge clk);
        end
        din.valid      <= 1'b1;
        din.mode       <= mode;
        din.value      <= value;
        din.row_masked <= masked;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        scatter_accumulate_step(mode, value, masked);
    endtask

    task automatic send_drain();
        send_beat(MODE_DRAIN, q_t'($urandom), 1'($urandom));
    endtask

    task automatic wait_for_outputs();
        din.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    // Bias wrap at the negative extreme, ties at both ends of the range, a single
    // masked element inside an unmasked row, and a drain in the middle of the row.
    task automatic test_row_extremes();
        send_beat(MODE_ELEMENT, 16'sh8000, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh8000, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh8000, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh7e00, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh7fff, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh1234, 1'b1);
        send_beat(MODE_ELEMENT, 16'sh5555, 1'b0);
        send_beat(MODE_ELEMENT, 16'shaaaa, 1'b0);
        send_drain();
        send_beat(MODE_ELEMENT, 16'shffff, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh0001, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh7fff, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh8000, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh0001, 1'b0);
        send_beat(MODE_ELEMENT, 16'shfffe, 1'b0);
        send_beat(MODE_ELEMENT, 16'sh00ff, 1'b0);
        send_beat(MODE_ELEMENT, 16'shff00, 1'b0);
    endtask

    // Masked row start: bias column goes to -1.0, all-zero tie keeps class 0.
    // The row is left open and finished by the random traffic.
    task automatic test_masked_row_start();
        send_drain();
        send_drain();
        for (int c = 0; c < ARG_COLUMNS; c++)
            send_beat(MODE_ELEMENT, q_t'($urandom), 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned gap_pct,
                                       input int unsigned hold_pct);
        int unsigned sent;
        logic        row_mask;
        sent = 0;
        source_gap_pct = gap_pct;
        sink_hold_pct  = hold_pct;
        while (sent < n_items)
        begin
            row_mask = ($urandom_range(99) < 20);
            do
            begin
                if ($urandom_range(99) < 8)
                begin
                    send_drain();
                    sent++;
                end
                // occasional flag flip on a single element
                send_beat(MODE_ELEMENT, pick_element(),
                          row_mask ^ ($urandom_range(99) < 4));
                sent++;
            end
            while (col_count != 0);
            if ($urandom_range(5) == 0)
            begin
                repeat (TABLE_WORDS)
                    send_drain();
                sent += TABLE_WORDS;
            end
            if ($urandom_range(9) == 0)
                wait_for_outputs();
        end
        wait_for_outputs();
    endtask

    // Drain up to and through the final entry so the last flag and wrap are seen.
    task automatic test_table_flush();
        do
            send_drain();
        while (drain_ptr != 0);
    endtask

    always @(posedge clk)
        dout.ready <= ($urandom_range(99) >= sink_hold_pct);

    always @(posedge clk)
    begin
        if (rst_n && dout.valid && dout.ready)
        begin
            rx_got = '{dout.kind, dout.result_value, dout.last};
            if (pending_beats.size() == 0)
            begin
                report_mismatch("unexpected beat", '0, rx_got);
            end
            else
            begin
                rx_want = pending_beats.pop_front();
                if (rx_got.kind !== rx_want.kind)
                    report_mismatch("kind", rx_want, rx_got);
                if (rx_got.data !== rx_want.data)
                    report_mismatch("result_value", rx_want, rx_got);
                if (rx_got.last !== rx_want.last)
                    report_mismatch("last", rx_want, rx_got);
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((din.valid && din.ready) || (dout.valid && dout.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        din.valid      = 1'b0;
        din.mode       = MODE_ELEMENT;
        din.value      = '0;
        din.row_masked = 1'b0;
        dout.ready     = 1'b0;
        source_gap_pct = 0;
        sink_hold_pct  = 0;
        mismatches     = 0;
        elem_beats     = 0;
        drain_beats    = 0;
        rows_closed    = 0;
        table_passes   = 0;
        stall_cycles   = 0;
        col_count      = 0;
        best_val       = '0;
        best_cls       = 0;
        drain_ptr      = 0;
        foreach (row_buf[i])
            row_buf[i] = '0;
        foreach (class_sums[i])
            class_sums[i] = '0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        test_row_extremes();
        test_masked_row_start();
        wait_for_outputs();
        test_random_traffic(330, 18, 65);
        test_random_traffic(330, 65, 18);
        test_random_traffic(330, 0, 0);
        test_table_flush();
        wait_for_outputs();

        repeat (ROW_WIDTH + 8)
            @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            $display("%0d results never arrived", pending_beats.size());
            mismatches += pending_beats.size();
        end

        $display("covered %0d element beats, %0d drain beats, %0d rows accumulated, %0d full table passes",
                 elem_beats, drain_beats, rows_closed, table_passes);
        $display("idle mixes: sender-light/receiver-heavy, the reverse, and none; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
rtl/core/acsa_pkg.sv
rtl/core/acsa_in_if.sv
rtl/core/acsa_out_if.sv
rtl/core/acsa_ctrl.sv
rtl/core/acsa_dp.sv
rtl/core/argmax_class_scatter_accumulate.sv
sim/tb.sv
